@@ rtl/core/lftb_pkg.sv @@
// ----------------------------------------------------------------------------
// lftb_pkg
// Shared types and constants for the LED frame temporal blend.
// ----------------------------------------------------------------------------
package lftb_pkg;

   localparam int PIXEL_COUNT_DEFAULT = 512;

   localparam int INDEX_W   = 9;
   localparam int CHAN_W    = 8;
   localparam int PIXEL_W   = 3 * CHAN_W;
   localparam int MIX_W     = 17;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = MIX_W;

   localparam logic [MIX_W-1:0] MIX_ONE = 17'h10000;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_MIX = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_FRAME  = 1'b1;

   typedef struct packed {
      logic [INDEX_W-1:0] pixel_index;
      logic [CHAN_W-1:0]  in_red;
      logic [CHAN_W-1:0]  in_green;
      logic [CHAN_W-1:0]  in_blue;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] out_index;
      logic [CHAN_W-1:0]  out_red;
      logic [CHAN_W-1:0]  out_green;
      logic [CHAN_W-1:0]  out_blue;
   } rsp_type;

endpackage

@@ rtl/core/lftb_ram.sv @@
// ----------------------------------------------------------------------------
// lftb_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// Read during write to the same address returns the old contents.
// ----------------------------------------------------------------------------
module lftb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/led_frame_temporal_blend.sv @@
// ----------------------------------------------------------------------------
// led_frame_temporal_blend
// Per-channel first-order blend of a pixel stream against a stored frame.
//
//   channel   ports                               direction  beat
//   request   req_valid req_stall req_data        in         one pixel
//   response  rsp_valid rsp_stall rsp_data        out        one blended pixel
//   csr       csr_wr_en csr_index csr_wr_data     in         one register write
//
// One pixel per cycle sustained while rsp_stall stays low; a request beat goes
// through the frame RAM read and the blend stage into the output register,
// which drives rsp_valid.
// Back-to-back pixels at the same index are served by forwarding the last
// written pixel around the RAM.
// After reset the frame RAM is cleared to black, one entry per cycle;
// req_stall stays high during that pass.
// A stalled response backs up into req_stall in the same cycle.
// ----------------------------------------------------------------------------
module led_frame_temporal_blend #(
   parameter int PIXEL_COUNT = lftb_pkg::PIXEL_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  lftb_pkg::req_type             req_data,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lftb_pkg::rsp_type             rsp_data,

   input  logic                          csr_wr_en,
   input  logic [lftb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lftb_pkg::CSR_W-1:0]    csr_wr_data
);

   import lftb_pkg::*;

   localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(PIXEL_COUNT - 1);

   // prev + (cur - prev) * mix, rounded; one multiply per channel
   function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] prev,
                                                    input logic [CHAN_W-1:0] cur,
                                                    input logic [MIX_W-1:0]  mix);
      logic signed [CHAN_W:0]          diff;
      logic signed [CHAN_W+MIX_W+1:0]  prod;
      logic signed [CHAN_W+MIX_W+1:0]  acc;
      diff = $signed({1'b0, cur}) - $signed({1'b0, prev});
      prod = diff * $signed({1'b0, mix});
      acc  = $signed({3'b000, prev, 16'h0000}) + prod + 27'sd32768;
      if (acc[26:24] != 3'b000) begin
         blend_chan = 8'hFF;
      end else begin
         blend_chan = acc[23:16];
      end
   endfunction

   // configuration
   logic [MIX_W-1:0] mix_ff;
   logic             hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ff  <= MIX_ONE;
         hold_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CURRENT_MIX: begin
               mix_ff <= (csr_wr_data[MIX_W-1:0] > MIX_ONE) ? MIX_ONE
                                                            : csr_wr_data[MIX_W-1:0];
            end
            CSR_HOLD_FRAME: begin
               hold_ff <= csr_wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // clearing pass after reset
   logic          clearing_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // pipeline
   logic          req_accept;
   logic          s1_valid_ff;
   logic          s1_adv;
   logic          s1_pass_ff;
   logic [AW-1:0] s1_addr_ff;
   req_type       s1_req_ff;
   logic          out_valid_ff;
   rsp_type       out_data_ff;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [PIXEL_W-1:0] ram_wdata;
   logic [PIXEL_W-1:0] ram_rdata;

   logic               wb_valid_ff;
   logic [AW-1:0]      wb_addr_ff;
   logic [PIXEL_W-1:0] wb_data_ff;

   logic [PIXEL_W-1:0] prev_pix;
   logic [PIXEL_W-1:0] blend_pix;
   rsp_type            s1_rsp;

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = clearing_ff || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff  <= req_data;
         s1_addr_ff <= AW'(req_data.pixel_index);
         s1_pass_ff <= hold_ff || (32'(req_data.pixel_index) >= 32'(PIXEL_COUNT));
      end
   end

   lftb_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (PIXEL_COUNT)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_accept),
      .rd_addr (AW'(req_data.pixel_index)),
      .rd_data (ram_rdata)
   );

   // RAM returns old data when the previous pixel wrote the same entry
   assign prev_pix = (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) ? wb_data_ff : ram_rdata;

   assign blend_pix = {blend_chan(prev_pix[23:16], s1_req_ff.in_red,   mix_ff),
                       blend_chan(prev_pix[15:8],  s1_req_ff.in_green, mix_ff),
                       blend_chan(prev_pix[7:0],   s1_req_ff.in_blue,  mix_ff)};

   always_comb begin
      s1_rsp.out_index = s1_req_ff.pixel_index;
      if (s1_pass_ff) begin
         s1_rsp.out_red   = s1_req_ff.in_red;
         s1_rsp.out_green = s1_req_ff.in_green;
         s1_rsp.out_blue  = s1_req_ff.in_blue;
      end else begin
         s1_rsp.out_red   = blend_pix[23:16];
         s1_rsp.out_green = blend_pix[15:8];
         s1_rsp.out_blue  = blend_pix[7:0];
      end
   end

   assign ram_we    = clearing_ff || (s1_adv && !s1_pass_ff);
   assign ram_waddr = clearing_ff ? clr_addr_ff : s1_addr_ff;
   assign ram_wdata = clearing_ff ? '0 : blend_pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else if (ram_we) begin
         wb_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         wb_addr_ff <= ram_waddr;
         wb_data_ff <= ram_wdata;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_data_ff <= s1_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // clear pass covers every entry before it ends
   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      $fell(clearing_ff) |-> ($past(clr_addr_ff) == LAST_ADDR))
      else $error("clear pass ended early");

   // a pixel leaving the blend stage shows up in the output register
   a_s1_to_out: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (out_valid_ff && out_data_ff.out_index == $past(s1_req_ff.pixel_index)))
      else $error("blend stage beat lost");

   // stored pixel matches the pixel sent out
   a_wb_matches_out: assert property (@(posedge clock) disable iff (reset)
      (ram_we && !clearing_ff) |=>
         ({out_data_ff.out_red, out_data_ff.out_green, out_data_ff.out_blue}
          == $past(ram_wdata)))
      else $error("write-back differs from response");

   // no request accepted while the RAM is being cleared
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |=> !s1_valid_ff || !$past(req_valid) || $past(s1_valid_ff))
      else $error("request taken during clear pass");

endmodule
